FILE: hdl/clayton_copula_loglik_accumulator_macros.svh
// ----------------------------------------------------------------------------
// Clayton log-likelihood accumulator assertion macros
// Concurrent checks on clk, masked while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CLAYTON_COPULA_LOGLIK_ACCUMULATOR_MACROS_SVH
`define CLAYTON_COPULA_LOGLIK_ACCUMULATOR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CCLA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ccla check failed");
// next-cycle implication
`define CCLA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ccla check failed");
`else
`define CCLA_ASSERT_NOW(lbl, ante, cons)
`define CCLA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/ccla_pkg.sv
// ----------------------------------------------------------------------------
// Clayton log-likelihood accumulator package
// Fixed-point formats, constants and sequencer states.
// ----------------------------------------------------------------------------
package ccla_pkg;

  localparam int MARGIN_FRAC_BITS = 24;
  localparam int THETA_FRAC_BITS  = 16;
  localparam int SUM_FRAC_BITS    = 16;

  localparam int IN_W   = 24;
  localparam int TERM_W = 40;
  localparam int SUM_W  = 48;

  // Q.32 shift from internal format down to the sum format
  localparam int RND_SH = 32 - SUM_FRAC_BITS;

  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
  // 33 * ln2 in Q.32: exponent arguments at or above this give zero
  localparam logic [47:0] EXP_LIMIT = 48'd98242467576;

  localparam logic [24:0] ONE_M = 25'd1 << MARGIN_FRAC_BITS;
  localparam logic [24:0] ONE_T = 25'd1 << THETA_FRAC_BITS;

  localparam logic [5:0] F_MARGIN = 6'(MARGIN_FRAC_BITS);
  localparam logic [5:0] F_THETA  = 6'(THETA_FRAC_BITS);
  localparam logic [5:0] F_Q32    = 6'd32;
  localparam logic [5:0] LN_K_TOP = 6'd33;
  localparam logic [4:0] LN_LAST  = 5'd29;

  localparam logic [3:0] EXP_TERMS    = 4'd13;
  localparam logic [6:0] DIV_BITS_INV = 7'd64;
  localparam logic [6:0] DIV_BITS_EXP = 7'd32;

  typedef enum logic [4:0] {
    S_IDLE, S_LU, S_LV, S_L1, S_A, S_B, S_P, S_E1, S_E2, S_LA, S_INV, S_NEG,
    S_RND, S_SUM,
    LN_NORM, LN_SQ, LN_RND, LN_FR, LN_KM, LN_FIN,
    EX_CHK, EX_RED, EX_MUL, EX_DQ, EX_DIV, EX_ACC, EX_SH,
    MU_LO, MU_HI, MU_ADD
  } ccla_state_t;

endpackage

FILE: hdl/clayton_copula_loglik_accumulator.sv
// ----------------------------------------------------------------------------
// Clayton copula log-likelihood accumulator
// Takes (u, v, theta, last) words on the in_ channel and returns one result
// word per input on the out_ channel: the Clayton log density of the pair
// (Q23.16), the saturating running sum including it (Q31.16), an echo of
// last_pair and a bad flag for a zero operand (term zero, sum unchanged).
// One 32x32 multiplier, one restoring divider and the adders around them
// run under a sequencer; in_ready is high only while the sequencer idles.
// A good pair runs four logarithms of 30 squarings each plus a normalize of
// up to 33 steps, two exponentials of 13 series terms each taking a 32-step
// divide, and a 64-step divide by theta. A bad pair skips the math, goes
// straight to S_SUM and shows out_valid once its result is loaded there.
// The result sits in an output register; the next word may be accepted
// while it waits, and the sequencer holds before loading the next result
// until out_ready frees that register. The sum clears after a last_pair
// result is loaded. Reset empties the output register and clears the sum.
// ----------------------------------------------------------------------------
`include "clayton_copula_loglik_accumulator_macros.svh"

module clayton_copula_loglik_accumulator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [23:0]        in_u_value,
  input  logic [23:0]        in_v_value,
  input  logic [23:0]        in_dependence,
  input  logic               in_last_pair,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [39:0] out_item_term,
  output logic signed [47:0] out_running_sum,
  output logic               out_set_done,
  output logic               out_bad_input
);

  ccla_pkg::ccla_state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [23:0] v_r, v_nxt, dep_r, dep_nxt;
  logic        last_r, last_nxt, bad_r, bad_nxt;

  logic [33:0] ln_x_r, ln_x_nxt;
  logic [5:0]  ln_k_r, ln_k_nxt, lnf_r, lnf_nxt;
  logic [30:0] m_r, m_nxt;
  logic [29:0] fr_r, fr_nxt;
  logic [4:0]  ln_cnt_r, ln_cnt_nxt;
  logic [31:0] frac_r, frac_nxt;
  logic signed [39:0] ln_res_r, ln_res_nxt;

  logic [31:0] mul_x, mul_y;
  logic [63:0] prod_r, prod_nxt;
  logic [47:0] opa_r, opa_nxt;
  logic [24:0] opb_r, opb_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [47:0] mul_res_r, mul_res_nxt;

  logic [47:0] ex_d_r, ex_d_nxt;
  logic [5:0]  ex_n_r, ex_n_nxt;
  logic [31:0] ex_r_r, ex_r_nxt;
  logic [32:0] term_e_r, term_e_nxt;
  logic signed [34:0] ex_s_r, ex_s_nxt;
  logic [3:0]  ex_k_r, ex_k_nxt;
  logic [32:0] ex_res_r, ex_res_nxt;

  logic [63:0] dv_n_r, dv_n_nxt;
  logic [23:0] dv_rem_r, dv_rem_nxt, dv_d_r, dv_d_nxt;
  logic [6:0]  dv_cnt_r, dv_cnt_nxt;

  logic [39:0] lu_r, lu_nxt, lv_r, lv_nxt;
  logic signed [39:0] ln1pt_r, ln1pt_nxt;
  logic [47:0] a_r, a_nxt, b_r, b_nxt, p_r, p_nxt, mx_r, mx_nxt;
  logic [32:0] e1_r, e1_nxt;
  logic [48:0] lna_r, lna_nxt;
  logic signed [65:0] t32_r, t32_nxt;
  logic signed [39:0] term_r, term_nxt;
  logic signed [47:0] sum_r, sum_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic signed [39:0] out_term_r, out_term_nxt;
  logic signed [47:0] out_sum_r, out_sum_nxt;
  logic               out_done_r, out_done_nxt, out_bad_r, out_bad_nxt;
  logic               out_load;

  // shared datapath pieces
  logic [24:0] u_clamp, v_clamp, dep_one;
  logic        in_bad;
  logic signed [7:0] kmf;
  logic [6:0]  kmf_mag;
  logic [63:0] sq_rnd, fr_rnd, mu_sum;
  logic [32:0] sq_t;
  logic signed [39:0] ln_km;
  logic [24:0] dv_sh, dv_diff;
  logic        dv_ge;
  logic [23:0] dv_rem_step;
  logic [63:0] dv_n_step;
  logic [31:0] ex_q;
  logic [32:0] ex_t, ex_pos;
  logic signed [34:0] sarg;
  logic [48:0] lna_val;
  logic [63:0] neg_sum;
  logic [65:0] t_mag, t_rsum, t_rm;
  logic signed [66:0] t_val;
  logic signed [48:0] ns;
  logic signed [47:0] ns_sat;
  logic [47:0] ab_diff_a, ab_diff_b;

  assign prod_nxt = {32'b0, mul_x} * {32'b0, mul_y};

  always_comb begin
    u_clamp  = ({1'b0, in_u_value} > ccla_pkg::ONE_M) ? ccla_pkg::ONE_M : {1'b0, in_u_value};
    v_clamp  = ({1'b0, v_r} > ccla_pkg::ONE_M) ? ccla_pkg::ONE_M : {1'b0, v_r};
    dep_one  = {1'b0, dep_r} + ccla_pkg::ONE_T;
    in_bad   = (in_u_value == 24'd0) || (in_v_value == 24'd0) || (in_dependence == 24'd0);
    kmf      = $signed({2'b00, ln_k_r}) - $signed({2'b00, lnf_r});
    kmf_mag  = kmf[7] ? 7'(-kmf) : kmf[6:0];
    sq_rnd   = prod_r + 64'h2000_0000;
    sq_t     = sq_rnd[62:30];
    fr_rnd   = prod_r + 64'h2000_0000;
    ln_km    = kmf[7] ? -$signed({2'b00, prod_r[37:0]}) : $signed({2'b00, prod_r[37:0]});
    mu_sum   = acc_r + {prod_r[31:0], 32'b0}
               + (64'd1 << (ccla_pkg::THETA_FRAC_BITS - 1));
    dv_sh    = {dv_rem_r, dv_n_r[63]};
    dv_diff  = dv_sh - {1'b0, dv_d_r};
    dv_ge    = dv_sh >= {1'b0, dv_d_r};
    dv_rem_step = dv_ge ? dv_diff[23:0] : dv_sh[23:0];
    dv_n_step   = {dv_n_r[62:0], dv_ge};
    // first series term is exactly one, so its product is just r
    ex_q     = term_e_r[32] ? ex_r_r : prod_r[63:32];
    ex_t     = {1'b0, dv_n_r[31:0]};
    ex_pos   = ex_s_r[34] ? 33'd0 : ex_s_r[32:0];
    sarg     = $signed({2'b00, ccla_pkg::ONE_Q32}) + $signed({2'b00, e1_r})
               - $signed({2'b00, ex_res_r});
    lna_val  = {1'b0, mx_r} + {10'b0, ln_res_r[38:0]};
    neg_sum  = {16'b0, p_r} + dv_n_r + {14'b0, lna_r, 1'b0};
    t_mag    = t32_r[65] ? 66'(-t32_r) : 66'(t32_r);
    t_rsum   = t_mag + (66'd1 << (ccla_pkg::RND_SH - 1));
    t_rm     = t_rsum >> ccla_pkg::RND_SH;
    t_val    = t32_r[65] ? -$signed({1'b0, t_rm}) : $signed({1'b0, t_rm});
    ns       = $signed({sum_r[47], sum_r}) + $signed({{9{term_r[39]}}, term_r});
    if (ns[48] != ns[47]) begin
      ns_sat = ns[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    end else begin
      ns_sat = ns[47:0];
    end
    ab_diff_a = a_r - b_r;
    ab_diff_b = b_r - a_r;
  end

  assign out_load = (state_r == ccla_pkg::S_SUM) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;   ret_nxt = ret_r;
    v_nxt = v_r;           dep_nxt = dep_r;   last_nxt = last_r;  bad_nxt = bad_r;
    ln_x_nxt = ln_x_r;     ln_k_nxt = ln_k_r; lnf_nxt = lnf_r;
    m_nxt = m_r;           fr_nxt = fr_r;     ln_cnt_nxt = ln_cnt_r;
    frac_nxt = frac_r;     ln_res_nxt = ln_res_r;
    mul_x = 32'd0;         mul_y = 32'd0;
    opa_nxt = opa_r;       opb_nxt = opb_r;   acc_nxt = acc_r;    mul_res_nxt = mul_res_r;
    ex_d_nxt = ex_d_r;     ex_n_nxt = ex_n_r; ex_r_nxt = ex_r_r;  term_e_nxt = term_e_r;
    ex_s_nxt = ex_s_r;     ex_k_nxt = ex_k_r; ex_res_nxt = ex_res_r;
    dv_n_nxt = dv_n_r;     dv_rem_nxt = dv_rem_r; dv_d_nxt = dv_d_r; dv_cnt_nxt = dv_cnt_r;
    lu_nxt = lu_r;         lv_nxt = lv_r;     ln1pt_nxt = ln1pt_r;
    a_nxt = a_r;           b_nxt = b_r;       p_nxt = p_r;        mx_nxt = mx_r;
    e1_nxt = e1_r;         lna_nxt = lna_r;   t32_nxt = t32_r;    term_nxt = term_r;
    sum_nxt = sum_r;
    out_term_nxt = out_term_r; out_sum_nxt = out_sum_r;
    out_done_nxt = out_done_r; out_bad_nxt = out_bad_r;
    out_valid_nxt = (out_valid_r && out_ready) ? 1'b0 : out_valid_r;

    unique case (state_r)
      ccla_pkg::S_IDLE: begin
        if (in_valid) begin
          v_nxt    = in_v_value;
          dep_nxt  = in_dependence;
          last_nxt = in_last_pair;
          bad_nxt  = in_bad;
          if (in_bad) begin
            term_nxt  = '0;
            state_nxt = ccla_pkg::S_SUM;
          end else begin
            ln_x_nxt  = {9'b0, u_clamp};
            lnf_nxt   = ccla_pkg::F_MARGIN;
            ln_k_nxt  = ccla_pkg::LN_K_TOP;
            ret_nxt   = ccla_pkg::S_LU;
            state_nxt = ccla_pkg::LN_NORM;
          end
        end
      end
      ccla_pkg::S_LU: begin
        lu_nxt    = $unsigned(-ln_res_r);
        ln_x_nxt  = {9'b0, v_clamp};
        lnf_nxt   = ccla_pkg::F_MARGIN;
        ln_k_nxt  = ccla_pkg::LN_K_TOP;
        ret_nxt   = ccla_pkg::S_LV;
        state_nxt = ccla_pkg::LN_NORM;
      end
      ccla_pkg::S_LV: begin
        lv_nxt    = $unsigned(-ln_res_r);
        ln_x_nxt  = {9'b0, dep_one};
        lnf_nxt   = ccla_pkg::F_THETA;
        ln_k_nxt  = ccla_pkg::LN_K_TOP;
        ret_nxt   = ccla_pkg::S_L1;
        state_nxt = ccla_pkg::LN_NORM;
      end
      ccla_pkg::S_L1: begin
        ln1pt_nxt = ln_res_r;
        opa_nxt   = {8'b0, lu_r};
        opb_nxt   = {1'b0, dep_r};
        ret_nxt   = ccla_pkg::S_A;
        state_nxt = ccla_pkg::MU_LO;
      end
      ccla_pkg::S_A: begin
        a_nxt     = mul_res_r;
        opa_nxt   = {8'b0, lv_r};
        ret_nxt   = ccla_pkg::S_B;
        state_nxt = ccla_pkg::MU_LO;
      end
      ccla_pkg::S_B: begin
        b_nxt     = mul_res_r;
        opa_nxt   = {8'b0, lu_r} + {8'b0, lv_r};
        opb_nxt   = dep_one;
        ret_nxt   = ccla_pkg::S_P;
        state_nxt = ccla_pkg::MU_LO;
      end
      ccla_pkg::S_P: begin
        p_nxt     = mul_res_r;
        mx_nxt    = (a_r > b_r) ? a_r : b_r;
        ex_d_nxt  = (a_r > b_r) ? ab_diff_a : ab_diff_b;
        ret_nxt   = ccla_pkg::S_E1;
        state_nxt = ccla_pkg::EX_CHK;
      end
      ccla_pkg::S_E1: begin
        e1_nxt    = ex_res_r;
        ex_d_nxt  = mx_r;
        ret_nxt   = ccla_pkg::S_E2;
        state_nxt = ccla_pkg::EX_CHK;
      end
      ccla_pkg::S_E2: begin
        // log argument below one is taken as one
        if (sarg < $signed({2'b00, ccla_pkg::ONE_Q32})) begin
          ln_x_nxt = {1'b0, ccla_pkg::ONE_Q32};
        end else begin
          ln_x_nxt = sarg[33:0];
        end
        lnf_nxt   = ccla_pkg::F_Q32;
        ln_k_nxt  = ccla_pkg::LN_K_TOP;
        ret_nxt   = ccla_pkg::S_LA;
        state_nxt = ccla_pkg::LN_NORM;
      end
      ccla_pkg::S_LA: begin
        lna_nxt    = lna_val;
        dv_n_nxt   = (64'(lna_val[47:0]) << ccla_pkg::THETA_FRAC_BITS)
                     + {41'b0, dep_r[23:1]};
        dv_rem_nxt = '0;
        dv_d_nxt   = dep_r;
        dv_cnt_nxt = ccla_pkg::DIV_BITS_INV;
        state_nxt  = ccla_pkg::S_INV;
      end
      ccla_pkg::S_INV: begin
        dv_n_nxt   = dv_n_step;
        dv_rem_nxt = dv_rem_step;
        dv_cnt_nxt = dv_cnt_r - 7'd1;
        if (dv_cnt_r == 7'd1) begin
          state_nxt = ccla_pkg::S_NEG;
        end
      end
      ccla_pkg::S_NEG: begin
        t32_nxt   = $signed({{26{ln1pt_r[39]}}, ln1pt_r}) - $signed({2'b00, neg_sum});
        state_nxt = ccla_pkg::S_RND;
      end
      ccla_pkg::S_RND: begin
        if (t_val > $signed({27'b0, 1'b0, {39{1'b1}}})) begin
          term_nxt = {1'b0, {39{1'b1}}};
        end else if (t_val < $signed({{27{1'b1}}, 1'b1, 39'b0})) begin
          term_nxt = {1'b1, 39'b0};
        end else begin
          term_nxt = t_val[39:0];
        end
        state_nxt = ccla_pkg::S_SUM;
      end
      ccla_pkg::S_SUM: begin
        // hold until the output register is free
        if (out_load) begin
          out_term_nxt  = term_r;
          out_sum_nxt   = ns_sat;
          out_done_nxt  = last_r;
          out_bad_nxt   = bad_r;
          out_valid_nxt = 1'b1;
          sum_nxt       = last_r ? '0 : ns_sat;
          state_nxt     = ccla_pkg::S_IDLE;
        end
      end
      ccla_pkg::LN_NORM: begin
        if (ln_x_r[33]) begin
          m_nxt      = ln_x_r[33:3];
          fr_nxt     = '0;
          ln_cnt_nxt = '0;
          state_nxt  = ccla_pkg::LN_SQ;
        end else begin
          ln_x_nxt = {ln_x_r[32:0], 1'b0};
          ln_k_nxt = ln_k_r - 6'd1;
        end
      end
      ccla_pkg::LN_SQ: begin
        mul_x     = {1'b0, m_r};
        mul_y     = {1'b0, m_r};
        state_nxt = ccla_pkg::LN_RND;
      end
      ccla_pkg::LN_RND: begin
        // square reached two: halve and emit a one bit
        if (sq_t[31]) begin
          m_nxt = sq_t[31:1];
          fr_nxt[ccla_pkg::LN_LAST - ln_cnt_r] = 1'b1;
        end else begin
          m_nxt = sq_t[30:0];
        end
        ln_cnt_nxt = ln_cnt_r + 5'd1;
        state_nxt  = (ln_cnt_r == ccla_pkg::LN_LAST) ? ccla_pkg::LN_FR : ccla_pkg::LN_SQ;
      end
      ccla_pkg::LN_FR: begin
        mul_x     = {2'b0, fr_r};
        mul_y     = ccla_pkg::LN2_Q32;
        state_nxt = ccla_pkg::LN_KM;
      end
      ccla_pkg::LN_KM: begin
        frac_nxt  = fr_rnd[61:30];
        mul_x     = {25'b0, kmf_mag};
        mul_y     = ccla_pkg::LN2_Q32;
        state_nxt = ccla_pkg::LN_FIN;
      end
      ccla_pkg::LN_FIN: begin
        ln_res_nxt = ln_km + $signed({8'b0, frac_r});
        state_nxt  = ret_r;
      end
      ccla_pkg::EX_CHK: begin
        if (ex_d_r >= ccla_pkg::EXP_LIMIT) begin
          ex_res_nxt = '0;
          state_nxt  = ret_r;
        end else begin
          ex_n_nxt  = '0;
          state_nxt = ccla_pkg::EX_RED;
        end
      end
      ccla_pkg::EX_RED: begin
        if (ex_d_r >= {16'b0, ccla_pkg::LN2_Q32}) begin
          ex_d_nxt = ex_d_r - {16'b0, ccla_pkg::LN2_Q32};
          ex_n_nxt = ex_n_r + 6'd1;
        end else begin
          ex_r_nxt   = ex_d_r[31:0];
          term_e_nxt = ccla_pkg::ONE_Q32;
          ex_s_nxt   = $signed({2'b00, ccla_pkg::ONE_Q32});
          ex_k_nxt   = 4'd1;
          state_nxt  = ccla_pkg::EX_MUL;
        end
      end
      ccla_pkg::EX_MUL: begin
        mul_x     = term_e_r[31:0];
        mul_y     = ex_r_r;
        state_nxt = ccla_pkg::EX_DQ;
      end
      ccla_pkg::EX_DQ: begin
        dv_n_nxt   = {ex_q, 32'b0};
        dv_rem_nxt = '0;
        dv_d_nxt   = {20'b0, ex_k_r};
        dv_cnt_nxt = ccla_pkg::DIV_BITS_EXP;
        state_nxt  = ccla_pkg::EX_DIV;
      end
      ccla_pkg::EX_DIV: begin
        dv_n_nxt   = dv_n_step;
        dv_rem_nxt = dv_rem_step;
        dv_cnt_nxt = dv_cnt_r - 7'd1;
        if (dv_cnt_r == 7'd1) begin
          state_nxt = ccla_pkg::EX_ACC;
        end
      end
      ccla_pkg::EX_ACC: begin
        term_e_nxt = ex_t;
        ex_s_nxt   = ex_k_r[0] ? ex_s_r - $signed({2'b00, ex_t})
                               : ex_s_r + $signed({2'b00, ex_t});
        ex_k_nxt   = ex_k_r + 4'd1;
        state_nxt  = (ex_k_r == ccla_pkg::EXP_TERMS) ? ccla_pkg::EX_SH : ccla_pkg::EX_MUL;
      end
      ccla_pkg::EX_SH: begin
        ex_res_nxt = ex_pos >> ex_n_r;
        state_nxt  = ret_r;
      end
      ccla_pkg::MU_LO: begin
        mul_x     = opa_r[31:0];
        mul_y     = {7'b0, opb_r};
        state_nxt = ccla_pkg::MU_HI;
      end
      ccla_pkg::MU_HI: begin
        acc_nxt   = prod_r;
        mul_x     = {16'b0, opa_r[47:32]};
        mul_y     = {7'b0, opb_r};
        state_nxt = ccla_pkg::MU_ADD;
      end
      ccla_pkg::MU_ADD: begin
        mul_res_nxt = 48'(mu_sum >> ccla_pkg::THETA_FRAC_BITS);
        state_nxt   = ret_r;
      end
      default: begin
        state_nxt = ccla_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ccla_pkg::S_IDLE;
      ret_r       <= ccla_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;           dep_r <= dep_nxt;     last_r <= last_nxt;   bad_r <= bad_nxt;
    ln_x_r <= ln_x_nxt;     ln_k_r <= ln_k_nxt;   lnf_r <= lnf_nxt;
    m_r <= m_nxt;           fr_r <= fr_nxt;       ln_cnt_r <= ln_cnt_nxt;
    frac_r <= frac_nxt;     ln_res_r <= ln_res_nxt;
    prod_r <= prod_nxt;     opa_r <= opa_nxt;     opb_r <= opb_nxt;
    acc_r <= acc_nxt;       mul_res_r <= mul_res_nxt;
    ex_d_r <= ex_d_nxt;     ex_n_r <= ex_n_nxt;   ex_r_r <= ex_r_nxt;
    term_e_r <= term_e_nxt; ex_s_r <= ex_s_nxt;   ex_k_r <= ex_k_nxt;
    ex_res_r <= ex_res_nxt;
    dv_n_r <= dv_n_nxt;     dv_rem_r <= dv_rem_nxt;
    dv_d_r <= dv_d_nxt;     dv_cnt_r <= dv_cnt_nxt;
    lu_r <= lu_nxt;         lv_r <= lv_nxt;       ln1pt_r <= ln1pt_nxt;
    a_r <= a_nxt;           b_r <= b_nxt;         p_r <= p_nxt;
    mx_r <= mx_nxt;         e1_r <= e1_nxt;       lna_r <= lna_nxt;
    t32_r <= t32_nxt;       term_r <= term_nxt;
    out_term_r <= out_term_nxt; out_sum_r <= out_sum_nxt;
    out_done_r <= out_done_nxt; out_bad_r <= out_bad_nxt;
  end

  assign in_ready        = (state_r == ccla_pkg::S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_item_term   = out_term_r;
  assign out_running_sum = out_sum_r;
  assign out_set_done    = out_done_r;
  assign out_bad_input   = out_bad_r;

  `CCLA_ASSERT_NEXT(a_bad_skips_math, in_valid && in_ready && in_bad, state_r == ccla_pkg::S_SUM)
  `CCLA_ASSERT_NEXT(a_sum_clears, out_load && last_r, sum_r == 48'sd0)
  `CCLA_ASSERT_NOW(a_bad_term_zero, out_valid && out_bad_input, out_item_term == 40'sd0)
  `CCLA_ASSERT_NOW(a_div_count_live, state_r == ccla_pkg::S_INV || state_r == ccla_pkg::EX_DIV, dv_cnt_r != 7'd0)

endmodule
